// ===== rtl/jbf_pkg.sv =====
// Shared types, codes and frame tables for the JSON brace and binary framer.
`default_nettype none

package jbf_pkg;

	// Verdict codes
	localparam logic [1:0] VERDICT_WAIT   = 2'd0;
	localparam logic [1:0] VERDICT_READY  = 2'd1;
	localparam logic [1:0] VERDICT_REJECT = 2'd2;

	// Frame kind codes
	localparam logic [1:0] KIND_JSON   = 2'd0;
	localparam logic [1:0] KIND_REBOOT = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_MAX_DEPTH  = 2'd0;
	localparam logic [1:0] REG_MAX_LENGTH = 2'd1;

	// Register reset values
	localparam logic [4:0]  MAX_DEPTH_RST  = 5'd16;
	localparam logic [10:0] MAX_LENGTH_RST = 11'd1044;

	// Marker bytes
	localparam logic [7:0] BYTE_OPEN  = 8'h7B;
	localparam logic [7:0] BYTE_CLOSE = 8'h7D;
	localparam logic [7:0] BYTE_QUOTE = 8'h22;
	localparam logic [7:0] BYTE_BIN   = 8'hFF;

	// Binary frames are a fixed 12 bytes
	localparam logic [10:0] BIN_LEN = 11'd12;

	// Scan mode, one-hot
	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_JSON = 3'b010,
		MODE_BIN  = 3'b100
	} scan_mode_t;

	typedef struct packed {
		scan_mode_t  mode;
		logic [4:0]  depth;
		logic        in_string;
		logic [10:0] pos;
		logic        reboot_ok;
		logic        search_ok;
	} scan_state_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [10:0] length;
		logic [1:0]  kind;
	} scan_result_t;

	localparam scan_state_t SCAN_CLEAR = '{
		mode:      MODE_IDLE,
		depth:     5'd0,
		in_string: 1'b0,
		pos:       11'd0,
		reboot_ok: 1'b1,
		search_ok: 1'b1
	};

	// Reboot request frame, byte by position
	function automatic logic [7:0] reboot_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'hFF;
			4'd1:    b = 8'hFF;
			4'd7:    b = 8'h02;
			4'd8:    b = 8'h07;
			4'd9:    b = 8'h31;
			4'd10:   b = 8'h5B;
			4'd11:   b = 8'hC9;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Search request frame, byte by position
	function automatic logic [7:0] search_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'hFF;
			4'd1:    b = 8'hFF;
			4'd7:    b = 8'h02;
			4'd8:    b = 8'h05;
			4'd10:   b = 8'h48;
			4'd11:   b = 8'h73;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/jbf_step.sv =====
// Next-state and verdict logic for one received byte.
`default_nettype none

module jbf_step import jbf_pkg::*; (
	input  scan_state_t  cur,
	input  logic [7:0]   data_byte,
	input  logic         scan_start,
	input  logic [4:0]   max_depth,
	input  logic [10:0]  max_length,
	output scan_state_t  nxt,
	output scan_result_t res
);

	always_comb begin
		scan_state_t st;
		logic [1:0]  verdict;
		logic [10:0] len;
		logic [1:0]  kind;
		logic [4:0]  depth_dn;

		st       = cur;
		verdict  = VERDICT_WAIT;
		len      = 11'd0;
		kind     = KIND_JSON;
		depth_dn = cur.depth - 5'd1;

		// First byte of a scan picks the framing
		if (scan_start || cur.mode == MODE_IDLE) begin
			st = SCAN_CLEAR;
			if (data_byte == BYTE_OPEN) begin
				st.mode = MODE_JSON;
			end else if (data_byte == BYTE_BIN) begin
				st.mode = MODE_BIN;
			end else begin
				verdict = VERDICT_REJECT;
			end
		end
		depth_dn = st.depth - 5'd1;

		case (st.mode)
			MODE_JSON: begin
				if (st.pos >= max_length) begin
					verdict = VERDICT_REJECT;
				end else begin
					st.pos = st.pos + 11'd1;
					if (st.in_string) begin
						if (data_byte == BYTE_QUOTE) st.in_string = 1'b0;
					end else if (data_byte == BYTE_QUOTE) begin
						st.in_string = 1'b1;
					end else if (data_byte == BYTE_OPEN) begin
						if (st.depth >= max_depth) begin
							verdict = VERDICT_REJECT;
						end else begin
							st.depth = st.depth + 5'd1;
						end
					end else if (data_byte == BYTE_CLOSE) begin
						if (st.depth == 5'd0) begin
							verdict = VERDICT_REJECT;
						end else begin
							st.depth = depth_dn;
							if (depth_dn == 5'd0) begin
								verdict = VERDICT_READY;
								len     = st.pos;
							end
						end
					end
				end
			end
			MODE_BIN: begin
				if (st.pos >= BIN_LEN) begin
					verdict = VERDICT_REJECT;
				end else begin
					if (data_byte != reboot_byte(st.pos[3:0])) st.reboot_ok = 1'b0;
					if (data_byte != search_byte(st.pos[3:0])) st.search_ok = 1'b0;
					st.pos = st.pos + 11'd1;
					// Verdict only on the last byte
					if (st.pos == BIN_LEN) begin
						if (st.reboot_ok) begin
							verdict = VERDICT_READY;
							kind    = KIND_REBOOT;
							len     = BIN_LEN;
						end else if (st.search_ok) begin
							verdict = VERDICT_READY;
							kind    = KIND_SEARCH;
							len     = BIN_LEN;
						end else begin
							verdict = VERDICT_REJECT;
						end
					end
				end
			end
			default: begin
			end
		endcase

		// Any verdict ends the scan
		if (verdict != VERDICT_WAIT) st = SCAN_CLEAR;

		nxt         = st;
		res.verdict = verdict;
		res.length  = len;
		res.kind    = kind;
	end

endmodule

`default_nettype wire

// ===== rtl/json_brace_and_binary_framer.sv =====
// Top level of the JSON brace and binary framer: handshakes, registers, result stage.
`default_nettype none

// Judges one received byte per beat and returns one verdict per byte: wait, frame
// ready with its length and kind, or reject. A byte is taken every clock cycle unless a
// waiting result is not taken; its verdict appears in the result register in the cycle
// after acceptance, and the input stays ready while that result waits as long as the
// result is taken in the same cycle. A byte with '{' as first byte of a scan starts JSON
// framing with brace depth tracking (quotes hide braces, backslashes are not special);
// 0xFF starts a 12-byte match against the reboot and search request frames. Registers
// max_depth (index 0) and max_length (index 1) are written through the cfg channel,
// which is always ready, and should be changed only while no byte is in flight.
module json_brace_and_binary_framer import jbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// byte input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        scan_start,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  verdict,
	output logic [10:0] frame_length,
	output logic [1:0]  frame_kind,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	scan_state_t  state_q;
	scan_state_t  state_nxt;
	scan_result_t res;
	logic [4:0]   max_depth_q;
	logic [10:0]  max_length_q;
	logic         out_valid_q;
	scan_result_t res_q;
	logic         in_beat;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_beat   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q  <= MAX_DEPTH_RST;
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_DEPTH:  max_depth_q  <= cfg_data[4:0];
				REG_MAX_LENGTH: max_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	jbf_step u_step (
		.cur        (state_q),
		.data_byte  (data_byte),
		.scan_start (scan_start),
		.max_depth  (max_depth_q),
		.max_length (max_length_q),
		.nxt        (state_nxt),
		.res        (res)
	);

	// Scan state advances on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_CLEAR;
		end else if (in_beat) begin
			state_q <= state_nxt;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (in_beat) res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign verdict      = res_q.verdict;
	assign frame_length = res_q.length;
	assign frame_kind   = res_q.kind;

endmodule

`default_nettype wire

// ===== rtl/jbf_checker.sv =====
// Port-level checks for the framer, bound to the top level.
`default_nettype none

module jbf_checker import jbf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  data_byte,
	input logic        scan_start,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  verdict,
	input logic [10:0] frame_length,
	input logic [1:0]  frame_kind
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict) &&
			$stable(frame_length) && $stable(frame_kind))
		else $error("stalled result changed");

	// Every accepted byte shows a result in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted byte gave no result");

	// Wait and reject carry no length and no kind
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict != VERDICT_READY |-> frame_length == 11'd0 &&
			frame_kind == KIND_JSON)
		else $error("length or kind set without ready");

	// Binary frames are always 12 bytes
	a_bin_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == VERDICT_READY && frame_kind != KIND_JSON |->
			frame_length == BIN_LEN)
		else $error("binary frame length wrong");

	// A forced start on an unknown first byte rejects at once
	a_bad_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && scan_start && data_byte != BYTE_OPEN &&
			data_byte != BYTE_BIN |=> out_valid && verdict == VERDICT_REJECT)
		else $error("unknown first byte not rejected");

endmodule

bind json_brace_and_binary_framer jbf_checker u_jbf_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for json_brace_and_binary_framer: directed table, random frames.
`timescale 1ns / 100ps

module testbench;
	import jbf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_BYTES = 60;
	localparam int NUM_PHASES  = 6;

	// Index with no register behind it; writes to it must change nothing
	localparam logic [1:0]  REG_UNUSED  = 2'd3;
	localparam logic [7:0]  BYTE_BSLASH = 8'h5C;
	localparam logic [7:0]  BYTE_ALPHA  = 8'h41;
	localparam logic [7:0]  BYTE_ZERO   = 8'h00;
	// Binary request frames, first byte in the top bits
	localparam logic [95:0] REBOOT_SEQ = 96'hFFFF_0000_0000_0002_0731_5BC9;
	localparam logic [95:0] SEARCH_SEQ = 96'hFFFF_0000_0000_0002_0500_4873;

	// One row of the directed table: a byte beat or a register write
	typedef struct packed {
		logic         is_cfg;
		logic [1:0]   reg_idx;
		logic [10:0]  value;
		logic         start;
		logic         typed;
		scan_result_t want;
	} stim_row_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte  = 8'd0;
	logic        scan_start = 1'b0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [1:0]  verdict;
	logic [10:0] frame_length;
	logic [1:0]  frame_kind;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index  = 2'd0;
	logic [10:0] cfg_data   = 11'd0;

	// Predicted framer state and register copies
	scan_mode_t  fr_mode;
	logic [4:0]  fr_depth;
	logic        fr_in_quote;
	logic [10:0] fr_pos;
	logic        fr_reboot_ok;
	logic        fr_search_ok;
	logic [4:0]  lim_depth;
	logic [10:0] lim_length;

	scan_result_t pending_verdicts[$];
	stim_row_t    dir_tab[$];

	int src_idle   = 20;
	int snk_idle   = 69;
	int cycles     = 0;
	int errors     = 0;
	int bytes_sent = 0;
	int reg_writes = 0;
	int n_json     = 0;
	int n_reboot   = 0;
	int n_search   = 0;
	int n_reject   = 0;

	json_brace_and_binary_framer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.scan_start   (scan_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.verdict      (verdict),
		.frame_length (frame_length),
		.frame_kind   (frame_kind),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Scan state back to idle; registers untouched
	function automatic void restart_scan();
		fr_mode      = MODE_IDLE;
		fr_depth     = 5'd0;
		fr_in_quote  = 1'b0;
		fr_pos       = 11'd0;
		fr_reboot_ok = 1'b1;
		fr_search_ok = 1'b1;
	endfunction

	// Verdict for one byte, advancing the predicted state
	function automatic scan_result_t judge_byte(input logic [7:0] b, input logic s);
		scan_result_t res;
		int idx;
		res = {VERDICT_WAIT, 11'd0, KIND_JSON};
		// start mark or idle scanner: this is a first byte
		if (s || fr_mode == MODE_IDLE) begin
			restart_scan();
			if (b == BYTE_OPEN) fr_mode = MODE_JSON;
			else if (b == BYTE_BIN) fr_mode = MODE_BIN;
			else res.verdict = VERDICT_REJECT;
		end
		if (fr_mode == MODE_JSON) begin
			// length check comes before the byte is looked at
			if (fr_pos >= lim_length) begin
				res.verdict = VERDICT_REJECT;
			end else begin
				fr_pos = fr_pos + 11'd1;
				if (fr_in_quote) begin
					if (b == BYTE_QUOTE) fr_in_quote = 1'b0;
				end else if (b == BYTE_QUOTE) begin
					fr_in_quote = 1'b1;
				end else if (b == BYTE_OPEN) begin
					if (fr_depth >= lim_depth) res.verdict = VERDICT_REJECT;
					else fr_depth = fr_depth + 5'd1;
				end else if (b == BYTE_CLOSE) begin
					if (fr_depth == 5'd0) begin
						res.verdict = VERDICT_REJECT;
					end else begin
						fr_depth = fr_depth - 5'd1;
						if (fr_depth == 5'd0) begin
							res.verdict = VERDICT_READY;
							res.length  = fr_pos;
						end
					end
				end
			end
		end else if (fr_mode == MODE_BIN) begin
			// exact match; a mismatch only shows on the last byte
			if (fr_pos >= BIN_LEN) begin
				res.verdict = VERDICT_REJECT;
			end else begin
				idx = int'(fr_pos);
				if (b != REBOOT_SEQ[95 - 8 * idx -: 8]) fr_reboot_ok = 1'b0;
				if (b != SEARCH_SEQ[95 - 8 * idx -: 8]) fr_search_ok = 1'b0;
				fr_pos = fr_pos + 11'd1;
				if (fr_pos == BIN_LEN) begin
					if (fr_reboot_ok) begin
						res = {VERDICT_READY, BIN_LEN, KIND_REBOOT};
					end else if (fr_search_ok) begin
						res = {VERDICT_READY, BIN_LEN, KIND_SEARCH};
					end else begin
						res.verdict = VERDICT_REJECT;
					end
				end
			end
		end
		if (res.verdict != VERDICT_WAIT) restart_scan();
		if (res.verdict != VERDICT_READY) begin
			res.length = 11'd0;
			res.kind   = KIND_JSON;
		end
		return res;
	endfunction

	function automatic stim_row_t byte_row(input logic [7:0] b, input logic s);
		stim_row_t r;
		r = '0;
		r.value = {3'd0, b};
		r.start = s;
		return r;
	endfunction

	function automatic stim_row_t fixed_row(input logic [7:0] b, input logic s,
			input scan_result_t want);
		stim_row_t r;
		r = byte_row(b, s);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [10:0] val);
		stim_row_t r;
		r = '0;
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.value   = val;
		return r;
	endfunction

	// One byte beat; valid is left high at the accepting edge for the caller to reuse
	task automatic send_byte(input logic [7:0] b, input logic s, input logic typed,
			input scan_result_t want);
		scan_result_t pred;
		while ($urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		scan_start <= s;
		do @(posedge clk); while (!in_ready);
		pred = judge_byte(b, s);
		pending_verdicts.push_back(typed ? want : pred);
		bytes_sent++;
	endtask

	// Hold off the sender until every outstanding verdict is back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Register write beat; more=1 keeps valid up for a following write
	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val, input logic more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (!more) cfg_valid <= 1'b0;
		case (idx)
			REG_MAX_DEPTH:  lim_depth  = val[4:0];
			REG_MAX_LENGTH: lim_length = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	// Result side: random back-pressure and in-order compare
	always @(posedge clk) begin : result_check
		scan_result_t want;
		out_ready <= ($urandom_range(0, 99) >= snk_idle);
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result beat with nothing expected: verdict %0d len %0d kind %0d",
						$time, verdict, frame_length, frame_kind);
			end else begin
				want = pending_verdicts.pop_front();
				if (verdict !== want.verdict || frame_length !== want.length ||
						frame_kind !== want.kind) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: expected verdict %0d len %0d kind %0d, got %0d %0d %0d",
							$time, want.verdict, want.length, want.kind,
							verdict, frame_length, frame_kind);
				end
				if (want.verdict == VERDICT_REJECT) n_reject++;
				else if (want.verdict == VERDICT_READY && want.kind == KIND_REBOOT) n_reboot++;
				else if (want.verdict == VERDICT_READY && want.kind == KIND_SEARCH) n_search++;
				else if (want.verdict == VERDICT_READY) n_json++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int ph, pick, n, depth, lim, i, k, phase_end;
		logic [95:0] seq;
		logic [10:0] wd, wl;
		logic s;

		restart_scan();
		lim_depth  = MAX_DEPTH_RST;
		lim_length = MAX_LENGTH_RST;

		// Directed table, starting from the reset register values
		dir_tab.push_back(fixed_row(BYTE_ALPHA, 1'b0, {VERDICT_REJECT, 11'd0, KIND_JSON}));
		dir_tab.push_back(fixed_row(BYTE_CLOSE, 1'b0, {VERDICT_REJECT, 11'd0, KIND_JSON}));
		// braces in a string are skipped; backslash does not escape the quote
		dir_tab.push_back(byte_row(BYTE_OPEN, 1'b1));
		dir_tab.push_back(byte_row(BYTE_QUOTE, 1'b0));
		dir_tab.push_back(byte_row(BYTE_CLOSE, 1'b0));
		dir_tab.push_back(byte_row(BYTE_BSLASH, 1'b0));
		dir_tab.push_back(byte_row(BYTE_QUOTE, 1'b0));
		dir_tab.push_back(byte_row(BYTE_CLOSE, 1'b0));
		// binary scan dropped by a start mark mid-scan
		dir_tab.push_back(byte_row(BYTE_BIN, 1'b0));
		dir_tab.push_back(byte_row(BYTE_BIN, 1'b0));
		dir_tab.push_back(byte_row(BYTE_OPEN, 1'b1));
		dir_tab.push_back(byte_row(BYTE_CLOSE, 1'b0));
		// complete search request
		for (i = 0; i < 11; i++)
			dir_tab.push_back(byte_row(SEARCH_SEQ[95 - 8 * i -: 8], i == 0));
		dir_tab.push_back(fixed_row(SEARCH_SEQ[7:0], 1'b0,
			{VERDICT_READY, BIN_LEN, KIND_SEARCH}));
		// tightest limits; upper data bits on the depth write are dropped
		dir_tab.push_back(reg_row(REG_MAX_DEPTH, 11'h7E1));
		dir_tab.push_back(reg_row(REG_MAX_LENGTH, 11'd12));
		dir_tab.push_back(byte_row(BYTE_OPEN, 1'b1));
		dir_tab.push_back(fixed_row(BYTE_OPEN, 1'b0, {VERDICT_REJECT, 11'd0, KIND_JSON}));
		dir_tab.push_back(fixed_row(BYTE_ZERO, 1'b0, {VERDICT_REJECT, 11'd0, KIND_JSON}));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		for (i = 0; i < dir_tab.size(); i++) begin
			if (dir_tab[i].is_cfg) begin
				if (i == 0 || !dir_tab[i - 1].is_cfg) drain();
				write_reg(dir_tab[i].reg_idx, dir_tab[i].value,
					i + 1 < dir_tab.size() && dir_tab[i + 1].is_cfg);
			end else begin
				send_byte(dir_tab[i].value[7:0], dir_tab[i].start, dir_tab[i].typed,
					dir_tab[i].want);
			end
		end

		// Random phases, each under its own register setting and one of three idle patterns
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			case (ph)
				0: begin src_idle = 20; snk_idle = 69; wd = 11'd16;   wl = 11'd1044; end
				1: begin src_idle = 20; snk_idle = 69; wd = 11'd1;    wl = 11'd12;   end
				2: begin src_idle = 69; snk_idle = 20; wd = 11'h7FF;  wl = 11'd2047; end
				3: begin src_idle = 69; snk_idle = 20; wd = 11'h540;  wl = 11'd40;   end
				4: begin src_idle = 0;  snk_idle = 0;  wd = 11'd3;    wl = 11'd20;   end
				default: begin
					src_idle = 0;
					snk_idle = 0;
					wd = 11'($urandom_range(1, 31));
					wl = 11'($urandom_range(12, 120));
				end
			endcase
			write_reg(REG_MAX_DEPTH, wd, 1'b1);
			write_reg(REG_MAX_LENGTH, wl, ph == 3);
			if (ph == 3) write_reg(REG_UNUSED, 11'($urandom), 1'b0);

			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					// JSON frame: nesting, strings, filler; some left unclosed
					lim   = $urandom_range(1, int'(lim_depth) + 1);
					n     = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 12);
					depth = 1;
					send_byte(BYTE_OPEN, $urandom_range(0, 3) != 0, 1'b0, '0);
					for (i = 0; i < n; i++) begin
						k = $urandom_range(0, 9);
						if (k < 3 && depth < lim) begin
							send_byte(BYTE_OPEN, 1'b0, 1'b0, '0);
							depth++;
						end else if (k < 5 && depth > 1) begin
							send_byte(BYTE_CLOSE, 1'b0, 1'b0, '0);
							depth--;
						end else if (k < 7) begin
							send_byte(BYTE_QUOTE, 1'b0, 1'b0, '0);
							repeat ($urandom_range(0, 4))
								send_byte(8'($urandom), 1'b0, 1'b0, '0);
							send_byte(BYTE_QUOTE, 1'b0, 1'b0, '0);
						end else begin
							send_byte(8'($urandom), 1'b0, 1'b0, '0);
						end
					end
					if ($urandom_range(0, 99) < 85) begin
						while (depth > 0) begin
							send_byte(BYTE_CLOSE, 1'b0, 1'b0, '0);
							depth--;
						end
					end
				end else if (pick < 82) begin
					// binary request, sometimes corrupted or cut short
					seq = $urandom_range(0, 1) ? REBOOT_SEQ : SEARCH_SEQ;
					if ($urandom_range(0, 99) < 35) begin
						k = $urandom_range(0, 11);
						seq[95 - 8 * k -: 8] = 8'($urandom);
					end
					n = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 11) : 12;
					for (i = 0; i < n; i++) begin
						s = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0);
						send_byte(seq[95 - 8 * i -: 8], s, 1'b0, '0);
					end
				end else begin
					// noise
					repeat ($urandom_range(1, 6))
						send_byte(8'($urandom), 1'($urandom), 1'b0, '0);
				end
			end
		end

		drain();
		$display("covered %0d bytes under %0d register writes in %0d phases",
			bytes_sent, reg_writes, NUM_PHASES);
		$display("frames ready: %0d JSON, %0d reboot, %0d search; %0d rejects",
			n_json, n_reboot, n_search, n_reject);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
